// ===== rtl/cbd_pkg.sv =====
// Package for the CRC-16 checked block deframer: constants, types and the CRC step.
`default_nettype none

package cbd_pkg;

  // Default geometry.
  localparam int DATA_BYTES_DEF = 32;
  localparam int COUNT_BITS_DEF = 24;

  // Field widths.
  localparam int BYTE_W     = 8;
  localparam int OFFSET_W   = 5;
  localparam int BCOUNT_W   = 24;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;
  localparam int CRC_W      = 16;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_COUNT   = CFG_IDX_W'(1);

  // CRC-16 constants, MSB first, no reflection, no final XOR.
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h8005;
  localparam logic [CRC_W-1:0] CRC_TOP  = 16'h8000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic consume;    // process the accepted byte
    logic start_run;  // check matched: set up emission of the packet
    logic push_err;   // load the error word into the output slot
    logic rd_en;      // read the packet store at the current address
    logic push_data;  // load the read byte into the output slot
  } cbd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic run_idle;     // halted or nothing left to deliver
    logic pos_is_lo;    // next byte is the low check byte
    logic mismatch;     // last check failed
    logic skip_beyond;  // offset skips the whole packet
    logic slot_free;    // output slot can take a word this cycle
    logic emit_last;    // byte being pushed ends this packet's run
  } cbd_stat_t;

  // One byte of CRC-16 update, eight shift steps.
  function automatic logic [CRC_W-1:0] crc16_update(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    logic             top;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      top = (c & CRC_TOP) != '0;
      c = {c[CRC_W-2:0], 1'b0};
      if (top) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cbd_if.sv =====
// Valid/ready channel interfaces for raw input, results and configuration writes.
`default_nettype none

interface cbd_raw_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  modport source (output valid, output raw_byte, input ready);
  modport sink (input valid, input raw_byte, output ready);
endinterface

interface cbd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       status;
  logic       last_of_run;
  logic       transfer_done;
  modport source (output valid, output data_byte, output status, output last_of_run,
                  output transfer_done, input ready);
  modport sink (input valid, input data_byte, input status, input last_of_run,
                input transfer_done, output ready);
endinterface

interface cbd_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [23:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/cbd_ctrl.sv =====
// Controller state machine: input acceptance, check decision and word emission.
`default_nettype none

module cbd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             raw_valid,
  output logic                  raw_ready,
  input  cbd_pkg::cbd_stat_t    stat,
  output cbd_pkg::cbd_cmd_t     cmd
);
  import cbd_pkg::*;

  typedef enum logic [3:0] {
    ST_ACCEPT = 4'b0001,
    ST_CHECK  = 4'b0010,
    ST_READ   = 4'b0100,
    ST_PUSH   = 4'b1000
  } cbd_state_t;

  cbd_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    raw_ready  = 1'b0;
    unique case (state)
      ST_ACCEPT: begin
        raw_ready = 1'b1;
        if (raw_valid && !stat.run_idle) begin
          cmd.consume = 1'b1;
          if (stat.pos_is_lo) begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (stat.mismatch) begin
          if (stat.slot_free) begin
            cmd.push_err = 1'b1;
            state_next   = ST_ACCEPT;
          end
        end else begin
          cmd.start_run = 1'b1;
          state_next    = stat.skip_beyond ? ST_ACCEPT : ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (stat.slot_free) begin
          cmd.push_data = 1'b1;
          state_next    = stat.emit_last ? ST_ACCEPT : ST_READ;
        end
      end
      default: begin
        state_next = ST_ACCEPT;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/cbd_datapath.sv =====
// Datapath: packet store, CRC accumulator, counters, configuration and output slot.
`default_nettype none

module cbd_datapath #(
  parameter int DATA_BYTES = cbd_pkg::DATA_BYTES_DEF,
  parameter int COUNT_BITS = cbd_pkg::COUNT_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  cbd_pkg::cbd_cmd_t                 cmd,
  output cbd_pkg::cbd_stat_t                stat,
  input  wire logic [cbd_pkg::BYTE_W-1:0]   raw_byte,
  input  wire logic                         cfg_we,
  input  wire logic [cbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cbd_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                              result_valid,
  input  wire logic                         result_ready,
  output logic [cbd_pkg::BYTE_W-1:0]        data_byte,
  output logic                              status,
  output logic                              last_of_run,
  output logic                              transfer_done
);
  import cbd_pkg::*;

  localparam int IDX_W = $clog2(DATA_BYTES);
  localparam int POS_W = $clog2(DATA_BYTES + 2);

  logic [BYTE_W-1:0]     mem [DATA_BYTES];
  logic [BYTE_W-1:0]     rd_data;
  logic [IDX_W-1:0]      rd_addr;
  logic [CRC_W-1:0]      crc;
  logic [POS_W-1:0]      pos;
  logic [BYTE_W-1:0]     check_hi;
  logic [COUNT_BITS-1:0] remaining;
  logic                  first_packet;
  logic                  halted;
  logic                  mismatch;
  logic [OFFSET_W-1:0]   start_offset;
  logic [BCOUNT_W-1:0]   byte_count;
  logic [BCOUNT_W-1:0]   byte_count_next;
  logic                  pos_in_data;
  logic                  pos_is_hi;
  logic                  store_we;
  logic                  remaining_is_one;

  assign pos_in_data      = 32'(pos) < DATA_BYTES;
  assign pos_is_hi        = pos == POS_W'(DATA_BYTES);
  assign store_we         = cmd.consume && pos_in_data;
  assign remaining_is_one = remaining == COUNT_BITS'(1);
  assign byte_count_next  = (cfg_index == REG_BYTE_COUNT) ? cfg_data[BCOUNT_W-1:0] : byte_count;

  assign stat.run_idle    = halted || (remaining == '0);
  assign stat.pos_is_lo   = pos == POS_W'(DATA_BYTES + 1);
  assign stat.mismatch    = mismatch;
  assign stat.skip_beyond = first_packet && (32'(start_offset) >= DATA_BYTES);
  assign stat.slot_free   = !result_valid || result_ready;
  assign stat.emit_last   = (rd_addr == IDX_W'(DATA_BYTES - 1)) || remaining_is_one;

  // Packet store: one write port for incoming data, one registered read port.
  always_ff @(posedge clk) begin
    if (store_we) begin
      mem[pos[IDX_W-1:0]] <= raw_byte;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Control state and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_offset <= '0;
      byte_count   <= '0;
      crc          <= CRC_INIT;
      pos          <= '0;
      remaining    <= '0;
      first_packet <= 1'b1;
      halted       <= 1'b0;
    end else if (cfg_we && (cfg_index == REG_START_OFFSET || cfg_index == REG_BYTE_COUNT)) begin
      if (cfg_index == REG_START_OFFSET) begin
        start_offset <= cfg_data[OFFSET_W-1:0];
      end
      byte_count   <= byte_count_next;
      crc          <= CRC_INIT;
      pos          <= '0;
      remaining    <= COUNT_BITS'(byte_count_next);
      first_packet <= 1'b1;
      halted       <= 1'b0;
    end else begin
      if (cmd.consume) begin
        if (pos_in_data) begin
          crc <= crc16_update(crc, raw_byte);
          pos <= pos + POS_W'(1);
        end else if (pos_is_hi) begin
          pos <= pos + POS_W'(1);
        end else begin
          crc <= CRC_INIT;
          pos <= '0;
        end
      end
      if (cmd.start_run) begin
        first_packet <= 1'b0;
      end
      if (cmd.push_err) begin
        halted <= 1'b1;
      end
      if (cmd.push_data) begin
        remaining <= remaining - COUNT_BITS'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.consume && pos_is_hi) begin
      check_hi <= raw_byte;
    end
    if (cmd.consume && !pos_in_data && !pos_is_hi) begin
      mismatch <= {check_hi, raw_byte} != crc;
    end
    if (cmd.start_run) begin
      rd_addr <= first_packet ? IDX_W'(start_offset) : '0;
    end else if (cmd.push_data) begin
      rd_addr <= rd_addr + IDX_W'(1);
    end
  end

  // Output slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.push_err || cmd.push_data) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_err) begin
      data_byte     <= '0;
      status        <= 1'b1;
      last_of_run   <= 1'b1;
      transfer_done <= 1'b1;
    end else if (cmd.push_data) begin
      data_byte     <= rd_data;
      status        <= 1'b0;
      last_of_run   <= stat.emit_last;
      transfer_done <= remaining_is_one;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/crc16_checked_block_deframer.sv =====
// Top level of the CRC-16 checked block deframer.
//
// The raw channel carries one stored byte per word. Packets are DATA_BYTES data
// bytes followed by a big-endian CRC-16 (polynomial 0x8005, seed 0xFFFF, MSB
// first, no final XOR) computed over the data bytes. The result channel gives
// verified data bytes, or one error word (status set, data zero) when a check
// fails, after which all raw words are swallowed until a register write.
// The configuration channel writes start_offset (index 0) and byte_count
// (index 1); either write restarts the transfer. It is always ready and must
// only be used while the block is idle.
// Data and check bytes are taken one per cycle while the block accepts them.
// After the low check byte it stops taking raw words while it checks, then
// reads each delivered byte from the single read port of the packet store
// and loads it into the output register before reading the next. The check,
// read and push states lie between the low check byte and the first word of
// a packet. A stalled receiver simply holds the output register and the
// emission waits; nothing is dropped. Synchronous reset clears both registers
// to zero, so the block swallows raw words until byte_count is written.
`default_nettype none

module crc16_checked_block_deframer #(
  parameter int DATA_BYTES = cbd_pkg::DATA_BYTES_DEF,
  parameter int COUNT_BITS = cbd_pkg::COUNT_BITS_DEF
) (
  input wire logic      clk,
  input wire logic      rst,
  cbd_raw_if.sink       raw,
  cbd_result_if.source  result,
  cbd_cfg_if.sink       cfg
);
  import cbd_pkg::*;

  cbd_cmd_t  cmd;
  cbd_stat_t stat;
  logic      cfg_we;

  // Configuration writes are always taken.
  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid;

  // The controller decides when words are taken and when results are loaded.
  cbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .raw_valid (raw.valid),
    .raw_ready (raw.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the store, CRC, counters and output register.
  cbd_datapath #(
    .DATA_BYTES (DATA_BYTES),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .raw_byte      (raw.raw_byte),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .data_byte     (result.data_byte),
    .status        (result.status),
    .last_of_run   (result.last_of_run),
    .transfer_done (result.transfer_done)
  );

endmodule

`default_nettype wire

// ===== rtl/cbd_checker.sv =====
// Port-level assertions for the deframer, bound to the top level.
`default_nettype none

module cbd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic [7:0] res_data_byte,
  input wire logic       res_status,
  input wire logic       res_last_of_run,
  input wire logic       res_transfer_done
);

  // A word offered and not taken is still offered in the next cycle.
  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result word withdrawn before it was taken");

  // An error word carries zero data and closes both the run and the transfer.
  a_error_word: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status |-> res_data_byte == 8'h00 && res_last_of_run && res_transfer_done)
    else $error("malformed error word");

  // The end of a transfer is always the end of a packet's run.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_transfer_done |-> res_last_of_run)
    else $error("transfer ended inside a run");

  // Nothing follows directly after the word that ends a transfer.
  a_quiet_after_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && res_transfer_done |=> !res_valid)
    else $error("result word after the end of the transfer");

endmodule

bind crc16_checked_block_deframer cbd_checker u_cbd_checker (
  .clk               (clk),
  .rst               (rst),
  .res_valid         (result.valid),
  .res_ready         (result.ready),
  .res_data_byte     (result.data_byte),
  .res_status        (result.status),
  .res_last_of_run   (result.last_of_run),
  .res_transfer_done (result.transfer_done)
);

`default_nettype wire
